>>> hw/rtl/mep_pkg.sv
`timescale 1ns / 1ps

package mep_pkg;

	localparam int COORD_W   = 10;
	localparam int DATA_W    = 32;
	localparam int STEP_W    = 31;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int FRAC_BITS = 26;
	// escape when zr^2 + zi^2 >= 16, i.e. bits at or above 2^(2*frac + 4)
	localparam int ESC_BIT   = 2 * FRAC_BITS + 4;
	localparam int PADDR_W   = 4;

	localparam logic [7:0] MAX_ITER   = 8'd255;
	localparam logic [7:0] GREEN_FOLD = 8'd122;
	localparam logic [7:0] COLOR_TOP  = 8'd255;

	localparam logic [1:0] REG_RE_MIN  = 2'd0;
	localparam logic [1:0] REG_IM_MIN  = 2'd1;
	localparam logic [1:0] REG_RE_STEP = 2'd2;
	localparam logic [1:0] REG_IM_STEP = 2'd3;

	localparam logic signed [DATA_W-1:0] RE_MIN_RST  = -32'sd134217728;
	localparam logic signed [DATA_W-1:0] IM_MIN_RST  = -32'sd134217728;
	localparam logic [STEP_W-1:0]        RE_STEP_RST = 31'd262144;
	localparam logic [STEP_W-1:0]        IM_STEP_RST = 31'd262144;

	typedef struct packed {
		logic signed [DATA_W-1:0] re_min;
		logic signed [DATA_W-1:0] im_min;
		logic [STEP_W-1:0]        re_step;
		logic [STEP_W-1:0]        im_step;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [7:0]         iterations;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
	} res_t;

	// clamp a wide signed value into the signed 32-bit range
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic fits;
		fits = (&v[PROD_W-1:DATA_W-1]) | ~(|v[PROD_W-1:DATA_W-1]);
		if (fits) begin
			sat32 = v[DATA_W-1:0];
		end else if (v[PROD_W-1]) begin
			sat32 = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sat32 = {1'b0, {(DATA_W-1){1'b1}}};
		end
	endfunction

endpackage

>>> hw/rtl/mep_mul.sv
`timescale 1ns / 1ps

module mep_mul (
	input  logic                                 clk,
	input  logic signed [mep_pkg::DATA_W-1:0]    a,
	input  logic signed [mep_pkg::DATA_W-1:0]    b,
	output logic signed [mep_pkg::PROD_W-1:0]    prod_q
);
	import mep_pkg::*;

	// shared signed multiplier, product registered
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

>>> hw/rtl/mep_cfg_regs.sv
`timescale 1ns / 1ps

module mep_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mep_pkg::PADDR_W-1:0]   paddr,
	input  logic [mep_pkg::DATA_W-1:0]    pwdata,
	output logic [mep_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	output mep_pkg::cfg_t                 cfg
);
	import mep_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[PADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.re_min  <= RE_MIN_RST;
			cfg_q.im_min  <= IM_MIN_RST;
			cfg_q.re_step <= RE_STEP_RST;
			cfg_q.im_step <= IM_STEP_RST;
		end else if (wr_en) begin
			case (idx)
				REG_RE_MIN:  cfg_q.re_min  <= pwdata;
				REG_IM_MIN:  cfg_q.im_min  <= pwdata;
				REG_RE_STEP: cfg_q.re_step <= pwdata[STEP_W-1:0];
				REG_IM_STEP: cfg_q.im_step <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_RE_MIN:  prdata = cfg_q.re_min;
			REG_IM_MIN:  prdata = cfg_q.im_min;
			REG_RE_STEP: prdata = {1'b0, cfg_q.re_step};
			REG_IM_STEP: prdata = {1'b0, cfg_q.im_step};
			default:     prdata = '0;
		endcase
	end

endmodule

>>> hw/rtl/mep_core.sv
`timescale 1ns / 1ps

module mep_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mep_pkg::COORD_W-1:0]   pixel_x,
	input  logic [mep_pkg::COORD_W-1:0]   pixel_y,
	input  mep_pkg::cfg_t                 cfg,
	output logic                          res_valid,
	input  logic                          res_ready,
	output mep_pkg::res_t                 res
);
	import mep_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CRE  = 4'd1;
	localparam logic [3:0] ST_CIM  = 4'd2;
	localparam logic [3:0] ST_CFIN = 4'd3;
	localparam logic [3:0] ST_RR   = 4'd4;
	localparam logic [3:0] ST_II   = 4'd5;
	localparam logic [3:0] ST_RI   = 4'd6;
	localparam logic [3:0] ST_CHK  = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [3:0]                state_q;
	logic [COORD_W-1:0]        px_q, py_q;
	logic signed [DATA_W-1:0]  cr_q, ci_q, zr_q, zi_q;
	logic signed [PROD_W-1:0]  rr_q, diff_q;
	logic                      esc_q;
	logic [7:0]                n_q;

	logic signed [DATA_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic [PROD_W-1:0]         mag_sum;
	logic signed [PROD_W-1:0]  c_sum, zr_next, zi_next;
	logic [7:0]                green;

	mep_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	always_comb begin
		case (state_q)
			ST_CRE: begin
				mul_a = DATA_W'(px_q);
				mul_b = DATA_W'(cfg.re_step);
			end
			ST_CIM: begin
				mul_a = DATA_W'(py_q);
				mul_b = DATA_W'(cfg.im_step);
			end
			ST_II: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			ST_RI: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
		endcase
	end

	// squares are non-negative, so the sum fits unsigned
	assign mag_sum = $unsigned(rr_q) + $unsigned(prod);
	assign c_sum   = PROD_W'((state_q == ST_CIM) ? cfg.re_min : cfg.im_min) + prod;
	assign zr_next = (diff_q >>> FRAC_BITS) + PROD_W'(cr_q);
	// floor(2*zr*zi / 2^frac) is the product shifted one place less
	assign zi_next = (prod >>> (FRAC_BITS - 1)) + PROD_W'(ci_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_CRE;
				ST_CRE:  state_q <= ST_CIM;
				ST_CIM:  state_q <= ST_CFIN;
				ST_CFIN: begin
					n_q     <= '0;
					state_q <= ST_RR;
				end
				ST_RR:   state_q <= ST_II;
				ST_II:   state_q <= ST_RI;
				ST_RI:   state_q <= ST_CHK;
				ST_CHK: begin
					if (n_q == MAX_ITER || esc_q) begin
						state_q <= ST_DONE;
					end else begin
						n_q     <= n_q + 8'd1;
						state_q <= ST_RR;
					end
				end
				ST_DONE: if (res_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				px_q <= pixel_x;
				py_q <= pixel_y;
			end
			ST_CIM:  cr_q <= sat32(c_sum);
			ST_CFIN: begin
				ci_q <= sat32(c_sum);
				zr_q <= '0;
				zi_q <= '0;
			end
			ST_II:   rr_q <= prod;
			ST_RI: begin
				diff_q <= rr_q - prod;
				esc_q  <= |mag_sum[PROD_W-1:ESC_BIT];
			end
			ST_CHK: begin
				zr_q <= sat32(zr_next);
				zi_q <= sat32(zi_next);
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

	assign green          = (n_q <= GREEN_FOLD) ? n_q : COLOR_TOP - n_q;
	assign res.x          = px_q;
	assign res.y          = py_q;
	assign res.iterations = n_q;
	assign res.green      = green;
	assign res.red        = green >> 1;
	assign res.blue       = green >> 1;

endmodule

>>> hw/rtl/mandelbrot_escape_pixel.sv
// timing grows with n = iterations (0..255): every step reuses the one shared
// 32x32 multiplier for zr^2, zi^2 and zr*zi in turn
// requests: one pixel at a time; the next request is taken while
// a finished result still waits in the output register
// reset: arst_n clears the sequencer and output valid, registers return to
// re_min = im_min = -2.0 and re_step = im_step = 2^-8
`timescale 1ns / 1ps

module mandelbrot_escape_pixel (
	input  logic                          clk,
	input  logic                          arst_n,
	// config port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mep_pkg::PADDR_W-1:0]   paddr,
	input  logic [mep_pkg::DATA_W-1:0]    pwdata,
	output logic [mep_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	// pixel request
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mep_pkg::COORD_W-1:0]   pixel_x,
	input  logic [mep_pkg::COORD_W-1:0]   pixel_y,
	// result
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mep_pkg::COORD_W-1:0]   out_x,
	output logic [mep_pkg::COORD_W-1:0]   out_y,
	output logic [7:0]                    iterations,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue
);
	import mep_pkg::*;

	cfg_t cfg;
	res_t res, out_q;
	logic res_valid, res_ready;
	logic out_valid_q;

	// register file; the user must write it only while the core is idle, the block does not enforce it
	mep_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: forms c, then loops square-and-add on the shared multiplier
	mep_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register: frees the core as soon as the slot is empty or draining
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_x      = out_q.x;
	assign out_y      = out_q.y;
	assign iterations = out_q.iterations;
	assign red        = out_q.red;
	assign green      = out_q.green;
	assign blue       = out_q.blue;

`ifndef SYNTH
	// an accepted request keeps the core busy on the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("core took no request");

	// no result can appear right after a request, the core must still form c and iterate
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared too early");

	// colour ramp matches the iteration count
	a_color_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((iterations <= GREEN_FOLD) ? (green == iterations)
			: (green == COLOR_TOP - iterations)) && red == (green >> 1) && blue == red)
		else $error("colour does not match iterations");
`endif

endmodule

>>> tb/sv/mep_escape_checker.sv
`timescale 1ns / 1ps

module mep_escape_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [mep_pkg::PADDR_W-1:0] paddr,
	input  logic [mep_pkg::DATA_W-1:0]  pwdata,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [mep_pkg::COORD_W-1:0] pixel_x,
	input  logic [mep_pkg::COORD_W-1:0] pixel_y,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [mep_pkg::COORD_W-1:0] out_x,
	input  logic [mep_pkg::COORD_W-1:0] out_y,
	input  logic [7:0]                  iterations,
	input  logic [7:0]                  red,
	input  logic [7:0]                  green,
	input  logic [7:0]                  blue,
	output int                          fail_count,
	output int                          open_count
);

	localparam longint          Q_HI      = 64'sd2147483647;
	localparam longint          Q_LO      = -64'sd2147483648;
	localparam longint unsigned ESCAPE_SQ = 64'd1 << mep_pkg::ESC_BIT;

	mep_pkg::cfg_t view;
	mep_pkg::res_t due_pixels[$];
	int            mismatches;

	function automatic longint clamp_q(input longint v);
		if (v > Q_HI) return Q_HI;
		if (v < Q_LO) return Q_LO;
		return v;
	endfunction

	// escape count and colour of one pixel under the current view
	function automatic mep_pkg::res_t predict_escape(
		input logic [mep_pkg::COORD_W-1:0] px,
		input logic [mep_pkg::COORD_W-1:0] py
	);
		longint          base, idx, inc, c_re, c_im, zr, zi, nr, ni;
		longint unsigned ar, ai;
		int              n;
		bit              done;
		logic [7:0]      cnt, ramp;
		mep_pkg::res_t   r;
		base = longint'(view.re_min);
		idx  = longint'(px);
		inc  = longint'(view.re_step);
		c_re = clamp_q(base + idx * inc);
		base = longint'(view.im_min);
		idx  = longint'(py);
		inc  = longint'(view.im_step);
		c_im = clamp_q(base + idx * inc);
		zr   = 0;
		zi   = 0;
		n    = 0;
		done = 1'b0;
		while (!done) begin
			ar = (zr < 0) ? -zr : zr;
			ai = (zi < 0) ? -zi : zi;
			if (n == int'(mep_pkg::MAX_ITER) || ar * ar + ai * ai >= ESCAPE_SQ) begin
				done = 1'b1;
			end else begin
				// exact products, floor back to q6.26
				nr = ((zr * zr - zi * zi) >>> mep_pkg::FRAC_BITS) + c_re;
				ni = ((2 * zr * zi) >>> mep_pkg::FRAC_BITS) + c_im;
				zr = clamp_q(nr);
				zi = clamp_q(ni);
				n++;
			end
		end
		cnt          = 8'(n);
		ramp         = (cnt <= mep_pkg::GREEN_FOLD) ? cnt : mep_pkg::COLOR_TOP - cnt;
		r.x          = px;
		r.y          = py;
		r.iterations = cnt;
		r.red        = ramp >> 1;
		r.green      = ramp;
		r.blue       = ramp >> 1;
		return r;
	endfunction

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mep_pkg::res_t want;
		string         at;
		if (!arst_n) begin
			view.re_min  <= mep_pkg::RE_MIN_RST;
			view.im_min  <= mep_pkg::IM_MIN_RST;
			view.re_step <= mep_pkg::RE_STEP_RST;
			view.im_step <= mep_pkg::IM_STEP_RST;
			due_pixels.delete();
			mismatches = 0;
			fail_count <= 0;
			open_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					mep_pkg::REG_RE_MIN:  view.re_min  <= pwdata;
					mep_pkg::REG_IM_MIN:  view.im_min  <= pwdata;
					mep_pkg::REG_RE_STEP: view.re_step <= pwdata[mep_pkg::STEP_W-1:0];
					mep_pkg::REG_IM_STEP: view.im_step <= pwdata[mep_pkg::STEP_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				due_pixels.push_back(predict_escape(pixel_x, pixel_y));
			end
			if (out_valid && !out_stall) begin
				if (due_pixels.size() == 0) begin
					$display("%0t ns: result (%0d,%0d) expected none, got one",
						$time, out_x, out_y);
					mismatches++;
				end else begin
					want = due_pixels.pop_front();
					at   = $sformatf(" of pixel (%0d,%0d)", want.x, want.y);
					check_field({"out_x", at}, int'(want.x), int'(out_x));
					check_field({"out_y", at}, int'(want.y), int'(out_y));
					check_field({"iterations", at}, int'(want.iterations),
						int'(iterations));
					check_field({"red", at}, int'(want.red), int'(red));
					check_field({"green", at}, int'(want.green), int'(green));
					check_field({"blue", at}, int'(want.blue), int'(blue));
				end
			end
			fail_count <= mismatches;
			open_count <= due_pixels.size();
		end
	end

endmodule

>>> tb/sv/tb_mandelbrot_escape_pixel.sv
`timescale 1ns / 1ps

module tb_mandelbrot_escape_pixel;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [mep_pkg::PADDR_W-1:0] paddr;
	logic [mep_pkg::DATA_W-1:0]  pwdata;
	logic [mep_pkg::DATA_W-1:0]  prdata;
	logic                        pready;
	logic                        in_valid;
	logic                        in_stall;
	logic [mep_pkg::COORD_W-1:0] pixel_x;
	logic [mep_pkg::COORD_W-1:0] pixel_y;
	logic                        out_valid;
	logic                        out_stall;
	logic [mep_pkg::COORD_W-1:0] out_x;
	logic [mep_pkg::COORD_W-1:0] out_y;
	logic [7:0]                  iterations;
	logic [7:0]                  red;
	logic [7:0]                  green;
	logic [7:0]                  blue;
	int                          fail_count;
	int                          open_count;

	// idle switches for the request side and the result side
	bit send_gaps;
	bit take_gaps;

	mandelbrot_escape_pixel u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_x      (out_x),
		.out_y      (out_y),
		.iterations (iterations),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	// watches both channels and the register port, predicts and compares
	mep_escape_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_x      (out_x),
		.out_y      (out_y),
		.iterations (iterations),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.fail_count (fail_count),
		.open_count (open_count)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// hard stop: worst case is every pixel at the full iteration count
	// plus the longest gaps on both sides, taken several times over
	initial begin : watchdog
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// result side: before each result draw a stall run, independent of out_valid
	initial begin : result_sink
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = take_gaps ? $urandom_range(0, 17) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			// the result is taken at the first edge with out_valid high
			do @(posedge clk); while (!out_valid);
		end
	end

	// one pixel request; returns in the step right after it was taken,
	// with in_valid still high so a back-to-back request needs no toggle
	task automatic send_pixel(
		input logic [mep_pkg::COORD_W-1:0] x,
		input logic [mep_pkg::COORD_W-1:0] y
	);
		int gap;
		gap = send_gaps ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_x  <= x;
		pixel_y  <= y;
		do @(posedge clk); while (in_stall);
	endtask

	// stop requesting and wait until every predicted result has been taken;
	// the first edge lets the checker count a request taken just before
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (open_count != 0);
	endtask

	// setup then access; psel stays high so writes can follow back to back
	task automatic write_reg(input logic [1:0] idx, input logic [mep_pkg::DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// new view of the plane, written only once the block has gone idle
	task automatic set_view(
		input logic [mep_pkg::DATA_W-1:0] re0,
		input logic [mep_pkg::DATA_W-1:0] im0,
		input logic [mep_pkg::DATA_W-1:0] re_inc,
		input logic [mep_pkg::DATA_W-1:0] im_inc
	);
		drain();
		write_reg(mep_pkg::REG_RE_MIN, re0);
		write_reg(mep_pkg::REG_IM_MIN, im0);
		write_reg(mep_pkg::REG_RE_STEP, re_inc);
		write_reg(mep_pkg::REG_IM_STEP, im_inc);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// random pixels; idling on each side reshuffled every 50 requests,
	// about one coordinate in ten pinned to a frame edge
	task automatic random_pixels(input int count);
		int                          k;
		logic [mep_pkg::COORD_W-1:0] x;
		logic [mep_pkg::COORD_W-1:0] y;
		for (k = 0; k < count; k++) begin
			if (k % 50 == 0) begin
				send_gaps = 1'($urandom_range(0, 1));
				take_gaps = 1'($urandom_range(0, 1));
			end
			x = 10'($urandom_range(0, 1023));
			y = 10'($urandom_range(0, 1023));
			if ($urandom_range(0, 9) == 0) x = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
			if ($urandom_range(0, 9) == 0) y = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
			send_pixel(x, y);
		end
	endtask

	initial begin : stimulus
		int                         p;
		int                         e;
		logic [mep_pkg::DATA_W-1:0] re_inc;
		logic [mep_pkg::DATA_W-1:0] im_inc;
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		pixel_x   = '0;
		pixel_y   = '0;
		send_gaps = 1'b1;
		take_gaps = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset view: -2..+2-2^-8 on both axes, 2^-8 per pixel
		send_pixel(10'd0, 10'd0);         // corner -2-2i
		send_pixel(10'd1023, 10'd1023);   // far corner
		send_pixel(10'd0, 10'd1023);
		send_pixel(10'd1023, 10'd0);
		send_pixel(10'd512, 10'd512);     // c = 0, never escapes, colour folds to black
		send_pixel(10'd0, 10'd512);       // c = -2, z sticks at +2
		send_pixel(10'd576, 10'd512);     // c = 0.25, cusp, converges slowly
		send_pixel(10'd577, 10'd512);     // just outside the cusp, long escape
		send_pixel(10'd448, 10'd512);     // c = -0.25, inside
		send_pixel(10'd320, 10'd512);     // c = -0.75, neck between bulbs
		send_pixel(10'd704, 10'd512);     // c = 0.75, quick escape
		send_pixel(10'd512, 10'd768);     // c = i, bounded cycle
		send_pixel(10'd512, 10'd1023);
		send_pixel(10'd1, 10'd1);
		send_pixel(10'd1022, 10'd1022);
		send_pixel(10'h2AA, 10'h155);     // alternating bit patterns
		send_pixel(10'h155, 10'h2AA);

		// extreme view: the imaginary part sits at or saturates to its top, escape after one step;
		// the step words carry bit 31 set, which the registers must drop
		set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd1023, 10'd0);
		send_pixel(10'd0, 10'd1023);
		random_pixels(100);

		// mirrored extremes
		set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		random_pixels(50);

		// back to the reset view for the bulk of the plane
		set_view(32'hF800_0000, 32'hF800_0000, 32'd262144, 32'd262144);
		random_pixels(300);

		// deep zoom at the cusp: counts spread across the mirrored ramp
		set_view(32'd16777216, 32'hFFF8_0000, 32'd1024, 32'd1024);
		random_pixels(300);

		// zero steps: every pixel lands on c = 0, full iteration count
		set_view(32'd0, 32'd0, 32'd0, 32'd0);
		random_pixels(20);

		// zero steps at c = -0.75 + 0.1i
		set_view(32'hFD00_0000, 32'h0066_6666, 32'd0, 32'd0);
		random_pixels(20);

		// random views; every fourth one is fully random words
		for (p = 0; p < 8; p++) begin
			if (p % 4 == 3) begin
				set_view($urandom(), $urandom(), $urandom(), $urandom());
			end else begin
				e      = $urandom_range(8, 18);
				re_inc = (32'd1 << e) | $urandom_range(0, (1 << e) - 1);
				e      = $urandom_range(8, 18);
				im_inc = (32'd1 << e) | $urandom_range(0, (1 << e) - 1);
				set_view(32'hF600_0000 + $urandom_range(0, 32'h0C00_0000),
					32'hFA00_0000 + $urandom_range(0, 32'h0800_0000), re_inc, im_inc);
			end
			random_pixels(130);
		end

		// all requests out: wait for the last result, then watch for strays
		drain();
		repeat (1100) @(posedge clk);
		if (fail_count == 0 && open_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/mep_pkg.sv
hw/rtl/mep_mul.sv
hw/rtl/mep_cfg_regs.sv
hw/rtl/mep_core.sv
hw/rtl/mandelbrot_escape_pixel.sv
tb/sv/mep_escape_checker.sv
tb/sv/tb_mandelbrot_escape_pixel.sv
